>>> src/i2c_slave_message_mailbox_core_defines.svh
// Assertion macros shared by the mailbox RTL.
// Each macro expands to one labeled concurrent assertion on i_clk, held off during reset.
`ifndef I2C_SLAVE_MESSAGE_MAILBOX_CORE_DEFINES_SVH
`define I2C_SLAVE_MESSAGE_MAILBOX_CORE_DEFINES_SVH

// same-cycle implication
`define I2CMBX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CMBX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/i2cmbx_pkg.sv
// Package for the I2C slave message mailbox: opcodes, message kinds,
// register map, reset values and the pipeline stage record. No dependencies.
`default_nettype none

package i2cmbx_pkg;

    localparam int BUF_DEPTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int LIDX_W  = 5;
    localparam int SIDX_W  = 5;
    localparam int KIND_W  = 2;
    localparam int NKIND   = 4;
    localparam int NCFG    = 8;
    localparam int CFGI_W  = 3;
    localparam int PADDR_W = 5;
    localparam int APB_W   = 32;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    // request opcodes
    localparam logic [OP_W-1:0] OP_ADDR_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_ADDR_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_BYTE_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_BYTE_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_TX_LOAD    = 3'd4;

    // message kinds, in match priority order
    localparam logic [KIND_W-1:0] KIND_VIBE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEMP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CAL  = 2'd3;

    // register map (index = paddr[4:2])
    localparam logic [CFGI_W-1:0] REG_VIBE_ID  = 3'd0;
    localparam logic [CFGI_W-1:0] REG_VIBE_LEN = 3'd1;
    localparam logic [CFGI_W-1:0] REG_LED_ID   = 3'd2;
    localparam logic [CFGI_W-1:0] REG_LED_LEN  = 3'd3;
    localparam logic [CFGI_W-1:0] REG_TEMP_ID  = 3'd4;
    localparam logic [CFGI_W-1:0] REG_TEMP_LEN = 3'd5;
    localparam logic [CFGI_W-1:0] REG_CAL_ID   = 3'd6;
    localparam logic [CFGI_W-1:0] REG_CAL_LEN  = 3'd7;

    localparam logic [BYTE_W-1:0] ID_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] LEN_RST = 8'd1;
    localparam logic [BYTE_W-1:0] CNT_MAX = 8'd255;

    // result record carried from the memory read stage to the output register
    typedef struct packed {
        logic              send_valid;
        logic              send_mem;
        logic              store_valid;
        logic [SIDX_W-1:0] store_index;
        logic [BYTE_W-1:0] store_byte;
        logic              done_valid;
        logic [KIND_W-1:0] done_kind;
        logic              overflow;
    } t_s1;

endpackage

`default_nettype wire

>>> src/i2c_slave_message_mailbox_core.sv
// I2C slave message mailbox: bus-event decoder, transmit store and message matcher.
// Depends on i2cmbx_pkg and i2c_slave_message_mailbox_core_defines.svh.
//
// Usage:
//   Input stream (i_s_*): one request per bus event or software load; tuser holds the
//   opcode, tdata the byte, load index and master nack. Output stream (o_m_*): exactly
//   one result per request, in request order.
//   APB port: eight 8-bit registers (id/length pairs for vibe, led, temp, cal) at
//   byte addresses 0x00..0x1C; write them only while no request is in flight.
//   Path: an accepted request is registered in the read stage (the synchronous
//   transmit-store read) and then in the output register.
//   Throughput: one request per cycle when not stalled; one write port (loads) and one
//   registered read port (address read and byte read requests) on the transmit store.
//   Reset: synchronous, active low; clears the pointers, byte count, message id and
//   the per-entry valid bits, sets the registers to id 0 / length 1, so every transmit entry
//   reads as zero at once. No clearing sweep is needed.
//   Stall: when the receiver holds i_m_tready low, the output register and the read
//   stage keep their results and o_s_tready drops once both are full.
`default_nettype none

`include "i2c_slave_message_mailbox_core_defines.svh"

module i2c_slave_message_mailbox_core #(
    parameter int BUF_DEPTH = i2cmbx_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [7:0] data_byte, [12:8] load_index, [13] master_nack, [15:14] zero
    input  wire logic [i2cmbx_pkg::S_DATA_W-1:0] i_s_tdata,
    // [2:0] op
    input  wire logic [i2cmbx_pkg::OP_W-1:0]     i_s_tuser,
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [0] send_valid, [8:1] send_byte, [9] store_valid, [14:10] store_index,
    // [22:15] store_byte, [23] done_valid, [25:24] done_kind, [26] overflow, [31:27] zero
    output logic [i2cmbx_pkg::M_DATA_W-1:0]      o_m_tdata,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [i2cmbx_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [i2cmbx_pkg::APB_W-1:0]    pwdata,
    output logic [i2cmbx_pkg::APB_W-1:0]         prdata,
    output logic                                 pready
);
    import i2cmbx_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PW = $clog2(BUF_DEPTH + 1);
    localparam int XW = (PW > LIDX_W) ? PW : LIDX_W;
    localparam logic [PW-1:0] PTR_END = PW'(BUF_DEPTH);

    // ---------------- configuration registers ----------------
    logic [BYTE_W-1:0] r_cfg [NCFG];
    logic              w_cfg_wr;
    logic [CFGI_W-1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[PADDR_W-1:2];
    assign prdata    = APB_W'(r_cfg[w_cfg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCFG; i++) begin
                r_cfg[i] <= i[0] ? LEN_RST : ID_RST;
            end
        end else if (w_cfg_wr) begin
            r_cfg[w_cfg_idx] <= pwdata[BYTE_W-1:0];
        end
    end

    // ---------------- handshake and pipeline control ----------------
    logic r_s1_vld;
    logic r_out_vld;
    logic w_out_adv;
    logic w_acc;

    assign w_out_adv  = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || w_out_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_vld;

    // ---------------- request fields ----------------
    logic [OP_W-1:0]   w_op;
    logic [BYTE_W-1:0] w_data;
    logic [LIDX_W-1:0] w_lidx;
    logic              w_nack;

    assign w_op   = i_s_tuser;
    assign w_data = i_s_tdata[7:0];
    assign w_lidx = i_s_tdata[12:8];
    assign w_nack = i_s_tdata[13];

    // ---------------- session state ----------------
    logic [PW-1:0]     r_tx_ptr, n_tx_ptr;
    logic [PW-1:0]     r_rx_ptr, n_rx_ptr;
    logic [BYTE_W-1:0] r_cnt,    n_cnt;
    logic [BYTE_W-1:0] r_msg_id, n_msg_id;

    // ---------------- transmit store ----------------
    logic [BYTE_W-1:0]    mem_tx [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] r_tx_vld;
    logic [BYTE_W-1:0]    r_rd_data;
    logic                 r_rd_vld;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_wr_addr;
    logic                 w_wr_en;
    logic [XW-1:0]        w_lidx_x;
    logic [XW-1:0]        w_rx_x;

    assign w_lidx_x  = XW'(w_lidx);
    assign w_wr_addr = w_lidx_x[AW-1:0];
    assign w_wr_en   = w_acc && (w_op == OP_TX_LOAD) && (w_lidx_x < XW'(BUF_DEPTH));
    assign w_rd_addr = (w_op == OP_BYTE_READ) ? r_tx_ptr[AW-1:0] : '0;
    assign w_rx_x    = XW'(r_rx_ptr);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_tx[w_wr_addr] <= w_data;
        end
        // hold read data while the read stage is stalled
        if (w_acc) begin
            r_rd_data <= mem_tx[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_vld <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_tx_vld[w_wr_addr] <= 1'b1;
            end
            if (w_acc) begin
                r_rd_vld <= r_tx_vld[w_rd_addr];
            end
        end
    end

    // ---------------- decode and state update ----------------
    t_s1 n_s1;
    t_s1 r_s1;

    always_comb begin
        n_tx_ptr = r_tx_ptr;
        n_rx_ptr = r_rx_ptr;
        n_cnt    = r_cnt;
        n_msg_id = r_msg_id;
        n_s1     = '0;
        case (w_op)
            OP_ADDR_WRITE: begin
                n_tx_ptr = '0;
                n_rx_ptr = '0;
                n_cnt    = '0;
            end
            OP_ADDR_READ: begin
                n_tx_ptr        = PW'(1);
                n_rx_ptr        = '0;
                n_cnt           = '0;
                n_s1.send_valid = 1'b1;
                n_s1.send_mem   = 1'b1;
            end
            OP_BYTE_WRITE: begin
                if (r_cnt != CNT_MAX) begin
                    n_cnt = r_cnt + BYTE_W'(1);
                end
                if (n_cnt == BYTE_W'(1)) begin
                    n_msg_id = w_data;
                end else if (r_rx_ptr < PTR_END) begin
                    n_s1.store_valid = 1'b1;
                    n_s1.store_index = w_rx_x[SIDX_W-1:0];
                    n_s1.store_byte  = w_data;
                    n_rx_ptr         = r_rx_ptr + PW'(1);
                end else begin
                    n_s1.overflow = 1'b1;
                end
                // scan from lowest priority so the first kind wins
                for (int k = NKIND - 1; k >= 0; k--) begin
                    if (n_msg_id == r_cfg[2*k] && n_cnt == r_cfg[2*k+1]) begin
                        n_s1.done_valid = 1'b1;
                        n_s1.done_kind  = KIND_W'(k);
                    end
                end
            end
            OP_BYTE_READ: begin
                if (!w_nack) begin
                    n_s1.send_valid = 1'b1;
                    if (r_tx_ptr < PTR_END) begin
                        n_s1.send_mem = 1'b1;
                        n_tx_ptr      = r_tx_ptr + PW'(1);
                    end else begin
                        n_s1.overflow = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_ptr <= '0;
            r_rx_ptr <= '0;
            r_cnt    <= '0;
            r_msg_id <= '0;
        end else if (w_acc) begin
            r_tx_ptr <= n_tx_ptr;
            r_rx_ptr <= n_rx_ptr;
            r_cnt    <= n_cnt;
            r_msg_id <= n_msg_id;
        end
    end

    // ---------------- read stage and output register ----------------
    logic [BYTE_W-1:0]   w_send_byte;
    logic [M_DATA_W-1:0] r_out;

    assign w_send_byte = (r_s1.send_mem && r_rd_vld) ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_vld <= w_acc;
            end
            if (w_out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1 <= n_s1;
        end
        if (w_out_adv && r_s1_vld) begin
            r_out <= M_DATA_W'({r_s1.overflow, r_s1.done_kind, r_s1.done_valid,
                                r_s1.store_byte, r_s1.store_index, r_s1.store_valid,
                                w_send_byte, r_s1.send_valid});
        end
    end

    assign o_m_tdata = r_out;

    // ---------------- assertions ----------------
    `I2CMBX_ASSERT_NOW(a_tx_ptr_range, 1'b1, r_tx_ptr <= PTR_END, "transmit pointer past store end")
    `I2CMBX_ASSERT_NOW(a_rx_ptr_range, 1'b1, r_rx_ptr <= PTR_END, "payload pointer past store end")
    `I2CMBX_ASSERT_NEXT(a_addr_read, w_acc && w_op == OP_ADDR_READ, r_s1_vld && r_tx_ptr == PW'(1) && r_s1.send_mem, "address read did not restart transmit")
    `I2CMBX_ASSERT_NOW(a_ovf_excl, r_s1_vld && r_s1.overflow, !r_s1.store_valid && !r_s1.send_mem, "overflow with stored or sent data")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for i2c_slave_message_mailbox_core: bus-event and load requests in,
// one result per request out, compared against an in-bench model of the mailbox.
// Depends on i2cmbx_pkg and the core RTL only.

module testbench;

    import i2cmbx_pkg::*;

    localparam int DEPTH    = BUF_DEPTH_DEF;
    localparam int IDLE_PCT = 14;

    // op codes the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // result word, first listed field at the top
    typedef struct packed {
        logic [4:0]        pad;
        logic              overflow;
        logic [KIND_W-1:0] done_kind;
        logic              done_valid;
        logic [BYTE_W-1:0] store_byte;
        logic [SIDX_W-1:0] store_index;
        logic              store_valid;
        logic [BYTE_W-1:0] send_byte;
        logic              send_valid;
    } mbx_result_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [S_DATA_W-1:0]  i_s_tdata  = '0;
    logic [OP_W-1:0]      i_s_tuser  = '0;
    logic                 i_m_tready = 1'b0;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [PADDR_W-1:0]   paddr      = '0;
    logic [APB_W-1:0]     pwdata     = '0;
    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire [M_DATA_W-1:0]   o_m_tdata;
    wire [APB_W-1:0]      prdata;
    wire                  pready;

    i2c_slave_message_mailbox_core #(
        .BUF_DEPTH (DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mailbox model state
    logic [BYTE_W-1:0] tx_mem [DEPTH];
    logic [5:0]        tx_ptr;
    logic [5:0]        rx_ptr;
    logic [BYTE_W-1:0] byte_cnt;
    logic [BYTE_W-1:0] msg_id;
    logic [BYTE_W-1:0] cfg_shadow [NCFG];

    mbx_result_t pending_results [$];
    mbx_result_t seen_result;
    mbx_result_t wanted_result;

    bit steady = 1'b0;
    int requests_sent;
    int sends_count;
    int stores_count;
    int done_count;
    int overflow_count;
    int mismatch_count;

    function automatic void mailbox_reset();
        for (int i = 0; i < DEPTH; i++) begin
            tx_mem[i] = '0;
        end
        tx_ptr   = '0;
        rx_ptr   = '0;
        byte_cnt = '0;
        msg_id   = '0;
        cfg_shadow[REG_VIBE_ID]  = ID_RST;
        cfg_shadow[REG_VIBE_LEN] = LEN_RST;
        cfg_shadow[REG_LED_ID]   = ID_RST;
        cfg_shadow[REG_LED_LEN]  = LEN_RST;
        cfg_shadow[REG_TEMP_ID]  = ID_RST;
        cfg_shadow[REG_TEMP_LEN] = LEN_RST;
        cfg_shadow[REG_CAL_ID]   = ID_RST;
        cfg_shadow[REG_CAL_LEN]  = LEN_RST;
    endfunction

    function automatic mbx_result_t mailbox_predict(input logic [OP_W-1:0] op,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic [LIDX_W-1:0] lidx,
                                                   input logic nack);
        mbx_result_t r;
        r = '0;
        case (op)
            OP_ADDR_WRITE: begin
                tx_ptr   = '0;
                rx_ptr   = '0;
                byte_cnt = '0;
            end
            OP_ADDR_READ: begin
                rx_ptr       = '0;
                byte_cnt     = '0;
                r.send_valid = 1'b1;
                r.send_byte  = tx_mem[0];
                tx_ptr       = 6'd1;
            end
            OP_BYTE_WRITE: begin
                if (byte_cnt != CNT_MAX) begin
                    byte_cnt++;
                end
                // first byte after the address is the message id
                if (byte_cnt == 8'd1) begin
                    msg_id = data;
                end else if (rx_ptr < DEPTH) begin
                    r.store_valid = 1'b1;
                    r.store_index = rx_ptr[SIDX_W-1:0];
                    r.store_byte  = data;
                    rx_ptr++;
                end else begin
                    r.overflow = 1'b1;
                end
                r.done_valid = 1'b1;
                if (msg_id == cfg_shadow[REG_VIBE_ID] && byte_cnt == cfg_shadow[REG_VIBE_LEN]) begin
                    r.done_kind = KIND_VIBE;
                end else if (msg_id == cfg_shadow[REG_LED_ID] &&
                             byte_cnt == cfg_shadow[REG_LED_LEN]) begin
                    r.done_kind = KIND_LED;
                end else if (msg_id == cfg_shadow[REG_TEMP_ID] &&
                             byte_cnt == cfg_shadow[REG_TEMP_LEN]) begin
                    r.done_kind = KIND_TEMP;
                end else if (msg_id == cfg_shadow[REG_CAL_ID] &&
                             byte_cnt == cfg_shadow[REG_CAL_LEN]) begin
                    r.done_kind = KIND_CAL;
                end else begin
                    r.done_valid = 1'b0;
                end
            end
            OP_BYTE_READ: begin
                if (!nack) begin
                    r.send_valid = 1'b1;
                    if (tx_ptr < DEPTH) begin
                        r.send_byte = tx_mem[tx_ptr];
                        tx_ptr++;
                    end else begin
                        r.overflow = 1'b1;
                    end
                end
            end
            OP_TX_LOAD: begin
                if (lidx < DEPTH) begin
                    tx_mem[lidx] = data;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                                input logic [LIDX_W-1:0] lidx, input logic nack);
        mbx_result_t r;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, nack, lidx, data};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        r = mailbox_predict(op, data, lidx, nack);
        pending_results.push_back(r);
        requests_sent++;
        sends_count    += r.send_valid;
        stores_count   += r.store_valid;
        done_count     += r.done_valid;
        overflow_count += r.overflow;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // leaves psel/penable high; the caller drops them after its last write
    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_W-BYTE_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        cfg_shadow[idx] = value;
    endtask

    task automatic set_message_config(input logic [7:0] vibe_id, input logic [7:0] vibe_len,
                                      input logic [7:0] led_id, input logic [7:0] led_len,
                                      input logic [7:0] temp_id, input logic [7:0] temp_len,
                                      input logic [7:0] cal_id, input logic [7:0] cal_len);
        drain_results();
        write_reg(REG_VIBE_ID, vibe_id);
        write_reg(REG_VIBE_LEN, vibe_len);
        write_reg(REG_LED_ID, led_id);
        write_reg(REG_LED_LEN, led_len);
        write_reg(REG_TEMP_ID, temp_id);
        write_reg(REG_TEMP_LEN, temp_len);
        write_reg(REG_CAL_ID, cal_id);
        write_reg(REG_CAL_LEN, cal_len);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset registers: id 0, length 1, so a lone id byte of 0 completes a vibe message
    task automatic test_reset_defaults();
        send_request(OP_ADDR_WRITE, 8'h00, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'h00, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'hFF, 5'h1F, 1'b1);
        send_request(OP_ADDR_READ, 8'hFF, 5'h1F, 1'b1);
        send_request(OP_BYTE_READ, 8'h00, 5'd0, 1'b0);
    endtask

    task automatic test_directed_messages();
        // vibe and led share id and length: vibe must win
        set_message_config(8'h5A, 8'd3, 8'h5A, 8'd3, 8'hFF, 8'd2, 8'h00, 8'd255);
        send_request(OP_TX_LOAD, 8'hFF, 5'd0, 1'b0);
        send_request(OP_TX_LOAD, 8'hA5, 5'd31, 1'b1);
        send_request(OP_TX_LOAD, 8'h00, 5'd1, 1'b0);
        for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++) begin
            send_request(OP_W'(u), 8'hFF, 5'h1F, 1'b1);
        end
        send_request(OP_ADDR_READ, 8'h00, 5'd0, 1'b0);
        send_request(OP_BYTE_READ, 8'h3C, 5'd7, 1'b0);
        send_request(OP_BYTE_READ, 8'hC3, 5'd24, 1'b1);
        send_request(OP_BYTE_READ, 8'h00, 5'd0, 1'b0);
        send_request(OP_ADDR_WRITE, 8'hFF, 5'h1F, 1'b1);
        send_request(OP_BYTE_WRITE, 8'h5A, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'h00, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'hFF, 5'd0, 1'b0);
        send_request(OP_ADDR_WRITE, 8'h00, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'hFF, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'h7E, 5'd0, 1'b0);
        send_request(OP_ADDR_WRITE, 8'h00, 5'd0, 1'b0);
        send_request(OP_BYTE_WRITE, 8'h00, 5'd0, 1'b0);
    endtask

    // fill every transmit entry, then read past the end of the store
    task automatic test_transmit_overrun();
        for (int i = 0; i < DEPTH; i++) begin
            send_request(OP_TX_LOAD, 8'($urandom), LIDX_W'(i), 1'($urandom));
        end
        send_request(OP_ADDR_READ, 8'($urandom), 5'($urandom), 1'($urandom));
        for (int j = 0; j < DEPTH + 2; j++) begin
            if (j == 10 || j == DEPTH) begin
                send_request(OP_BYTE_READ, 8'($urandom), 5'($urandom), 1'b1);
            end
            send_request(OP_BYTE_READ, 8'($urandom), 5'($urandom), 1'b0);
        end
    endtask

    // long message: payload store fills, count pins at 255 and keeps matching;
    // zero lengths never match, temp outranks cal
    task automatic test_count_saturation();
        set_message_config(8'h3C, 8'd0, 8'h3C, 8'd0, 8'h3C, 8'd255, 8'h3C, 8'd255);
        send_request(OP_ADDR_WRITE, 8'($urandom), 5'($urandom), 1'($urandom));
        send_request(OP_BYTE_WRITE, 8'h3C, 5'($urandom), 1'($urandom));
        for (int j = 0; j < 260; j++) begin
            send_request(OP_BYTE_WRITE, 8'($urandom), 5'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int phase);
        logic [7:0] ids  [NKIND];
        logic [7:0] lens [NKIND];
        logic [7:0] msg;
        int         goal;
        int         pick;
        int         k;
        int         n;
        for (int i = 0; i < NKIND; i++) begin
            case ($urandom_range(0, 3))
                0:       ids[i] = 8'h00;
                1:       ids[i] = 8'hFF;
                default: ids[i] = 8'($urandom_range(1, 4));
            endcase
            lens[i] = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
        end
        set_message_config(ids[0], lens[0], ids[1], lens[1], ids[2], lens[2], ids[3], lens[3]);
        steady = (phase == 1);
        goal   = requests_sent + 100;
        while (requests_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // write message, mostly with a configured id and about the right length
                k   = $urandom_range(0, NKIND - 1);
                msg = ($urandom_range(0, 4) == 0) ? 8'($urandom) : ids[k];
                n   = ((lens[k] > 12) ? 12 : lens[k]) - 1 + $urandom_range(0, 2)
                      - (($urandom_range(0, 3) == 0) ? 2 : 0);
                send_request(OP_ADDR_WRITE, 8'($urandom), 5'($urandom), 1'($urandom));
                send_request(OP_BYTE_WRITE, msg, 5'($urandom), 1'($urandom));
                for (int j = 0; j < n; j++) begin
                    send_request(OP_BYTE_WRITE, 8'($urandom), 5'($urandom), 1'($urandom));
                end
            end else if (pick < 80) begin
                n = $urandom_range(1, 6);
                send_request(OP_ADDR_READ, 8'($urandom), 5'($urandom), 1'($urandom));
                for (int j = 0; j < n; j++) begin
                    send_request(OP_BYTE_READ, 8'($urandom), 5'($urandom),
                                 ($urandom_range(0, 4) == 0));
                end
            end else if (pick < 90) begin
                send_request(OP_TX_LOAD, 8'($urandom), 5'($urandom), 1'($urandom));
            end else begin
                send_request(OP_W'($urandom_range(0, 7)), 8'($urandom), 5'($urandom),
                             1'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    // accept results and compare with the oldest pending prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_result = mbx_result_t'(o_m_tdata);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result %08h arrived with nothing pending", $time, o_m_tdata);
                end
            end else begin
                wanted_result = pending_results.pop_front();
                if (seen_result.send_valid  !== wanted_result.send_valid  ||
                    seen_result.send_byte   !== wanted_result.send_byte   ||
                    seen_result.store_valid !== wanted_result.store_valid ||
                    seen_result.store_index !== wanted_result.store_index ||
                    seen_result.store_byte  !== wanted_result.store_byte  ||
                    seen_result.done_valid  !== wanted_result.done_valid  ||
                    seen_result.done_kind   !== wanted_result.done_kind   ||
                    seen_result.overflow    !== wanted_result.overflow) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: want send %b/%h store %b/%0d/%h done %b/%0d ovf %b",
                                 $time, wanted_result.send_valid, wanted_result.send_byte,
                                 wanted_result.store_valid, wanted_result.store_index,
                                 wanted_result.store_byte, wanted_result.done_valid,
                                 wanted_result.done_kind, wanted_result.overflow);
                        $display("%0t:  got send %b/%h store %b/%0d/%h done %b/%0d ovf %b",
                                 $time, seen_result.send_valid, seen_result.send_byte,
                                 seen_result.store_valid, seen_result.store_index,
                                 seen_result.store_byte, seen_result.done_valid,
                                 seen_result.done_kind, seen_result.overflow);
                    end
                end
            end
        end
        i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        #2_000_000;
        $display("run did not finish in time, %0d results still pending",
                 pending_results.size());
        $display("FAIL i2c_slave_message_mailbox_core");
        $finish;
    end

    initial begin
        mailbox_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_messages();
        test_transmit_overrun();
        test_count_saturation();
        for (int p = 0; p < 3; p++) begin
            test_random_traffic(p);
        end
        drain_results();
        $display("%0d requests: %0d bytes sent, %0d payload stores, %0d completions",
                 requests_sent, sends_count, stores_count, done_count);
        $display("%0d overflows, %0d mismatches", overflow_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS i2c_slave_message_mailbox_core");
        end else begin
            $display("FAIL i2c_slave_message_mailbox_core");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/i2cmbx_pkg.sv
src/i2c_slave_message_mailbox_core.sv
test/testbench.sv
